/* sv/csb_pkg.sv */
package csb_pkg;

  localparam int DEST_WIDTH_DEF  = 1024;
  localparam int DEST_HEIGHT_DEF = 1024;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int EDGE_W  = 11;
  localparam int ORG_W   = 12;
  localparam int ALPHA_W = 9;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 11;
  localparam int RGB_W   = 24;
  localparam int DADDR_W = 20;
  // signed working width for destination coordinates
  localparam int POS_W   = 14;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT,
    REG_CLIP_TOP,
    REG_CLIP_RIGHT,
    REG_CLIP_BOTTOM,
    REG_SPRITE_WIDTH,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ALPHA
  } reg_idx_t;

  localparam logic [EDGE_W-1:0]  CLIP_RIGHT_RST   = EDGE_W'(1024);
  localparam logic [EDGE_W-1:0]  CLIP_BOTTOM_RST  = EDGE_W'(1024);
  localparam logic [EDGE_W-1:0]  SPRITE_WIDTH_RST = EDGE_W'(1);
  localparam logic [ALPHA_W-1:0] ALPHA_FULL       = ALPHA_W'(256);

  typedef struct packed {
    logic [EDGE_W-1:0]         clip_left;
    logic [EDGE_W-1:0]         clip_top;
    logic [EDGE_W-1:0]         clip_right;
    logic [EDGE_W-1:0]         clip_bottom;
    logic [EDGE_W-1:0]         sprite_width;
    logic signed [ORG_W-1:0]   origin_x;
    logic signed [ORG_W-1:0]   origin_y;
    logic [ALPHA_W-1:0]        alpha;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [DADDR_W-1:0] addr;
  } clip_res_t;

endpackage

/* sv/csb_cfg.sv */
module csb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csb_pkg::ADDR_W-1:0]  paddr,
  input  logic [csb_pkg::DATA_W-1:0]  pwdata,
  output logic [csb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output csb_pkg::cfg_t               cfg
);
  import csb_pkg::*;

  cfg_t     cfg_next;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      case (idx)
        REG_CLIP_LEFT:    cfg_next.clip_left    = pwdata[EDGE_W-1:0];
        REG_CLIP_TOP:     cfg_next.clip_top     = pwdata[EDGE_W-1:0];
        REG_CLIP_RIGHT:   cfg_next.clip_right   = pwdata[EDGE_W-1:0];
        REG_CLIP_BOTTOM:  cfg_next.clip_bottom  = pwdata[EDGE_W-1:0];
        REG_SPRITE_WIDTH: cfg_next.sprite_width = pwdata[EDGE_W-1:0];
        REG_ORIGIN_X:     cfg_next.origin_x     = $signed(pwdata[ORG_W-1:0]);
        REG_ORIGIN_Y:     cfg_next.origin_y     = $signed(pwdata[ORG_W-1:0]);
        REG_ALPHA:        cfg_next.alpha        = pwdata[ALPHA_W-1:0];
        default:          cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left    <= '0;
      cfg.clip_top     <= '0;
      cfg.clip_right   <= CLIP_RIGHT_RST;
      cfg.clip_bottom  <= CLIP_BOTTOM_RST;
      cfg.sprite_width <= SPRITE_WIDTH_RST;
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.alpha        <= ALPHA_FULL;
    end else begin
      cfg <= cfg_next;
    end
  end

  always_comb begin
    case (idx)
      REG_CLIP_LEFT:    prdata = DATA_W'(cfg.clip_left);
      REG_CLIP_TOP:     prdata = DATA_W'(cfg.clip_top);
      REG_CLIP_RIGHT:   prdata = DATA_W'(cfg.clip_right);
      REG_CLIP_BOTTOM:  prdata = DATA_W'(cfg.clip_bottom);
      REG_SPRITE_WIDTH: prdata = DATA_W'(cfg.sprite_width);
      REG_ORIGIN_X:     prdata = DATA_W'($unsigned(cfg.origin_x));
      REG_ORIGIN_Y:     prdata = DATA_W'($unsigned(cfg.origin_y));
      REG_ALPHA:        prdata = DATA_W'(cfg.alpha);
      default:          prdata = '0;
    endcase
  end

endmodule

/* sv/csb_walk.sv */
module csb_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        last_pixel,
  input  logic [csb_pkg::EDGE_W-1:0]  sprite_width,
  output logic [csb_pkg::COL_W-1:0]   col,
  output logic [csb_pkg::ROW_W-1:0]   row
);
  import csb_pkg::*;

  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W:0]   col_inc;
  logic             wrap;

  assign col_inc = {1'b0, col} + (COL_W+1)'(1);
  // width 0 behaves as width 1, which this compare gives for free
  assign wrap    = EDGE_W'(col_inc) >= sprite_width;

  always_comb begin
    col_next = col;
    row_next = row;
    if (advance) begin
      if (last_pixel) begin
        col_next = '0;
        row_next = '0;
      end else if (wrap) begin
        col_next = '0;
        row_next = row + ROW_W'(1);
      end else begin
        col_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* sv/csb_clip.sv */
module csb_clip #(
  parameter int DEST_WIDTH  = csb_pkg::DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT = csb_pkg::DEST_HEIGHT_DEF
) (
  input  csb_pkg::cfg_t               cfg,
  input  logic [csb_pkg::COL_W-1:0]   col,
  input  logic [csb_pkg::ROW_W-1:0]   row,
  input  logic                        opaque,
  output csb_pkg::clip_res_t          res
);
  import csb_pkg::*;

  logic signed [POS_W-1:0] x;
  logic signed [POS_W-1:0] y;
  logic                    in_x;
  logic                    in_y;
  logic [31:0]             row_base;

  assign x = POS_W'($signed(cfg.origin_x)) + $signed(POS_W'(col));
  assign y = POS_W'($signed(cfg.origin_y)) + $signed(POS_W'(row));

  // clip edges are never negative, so a negative coordinate fails the low test
  assign in_x = (x >= $signed(POS_W'(cfg.clip_left)))
             && (x <  $signed(POS_W'(cfg.clip_right)))
             && (x <  $signed(POS_W'(DEST_WIDTH)));
  assign in_y = (y >= $signed(POS_W'(cfg.clip_top)))
             && (y <  $signed(POS_W'(cfg.clip_bottom)))
             && (y <  $signed(POS_W'(DEST_HEIGHT)));

  assign row_base = 32'(y[EDGE_W-1:0]) * 32'(DEST_WIDTH);

  assign res.hit  = opaque && in_x && in_y;
  assign res.addr = row_base[DADDR_W-1:0] + DADDR_W'(x[EDGE_W-1:0]);

endmodule

/* sv/csb_blend.sv */
module csb_blend (
  input  logic [csb_pkg::ALPHA_W-1:0] alpha,
  input  logic [csb_pkg::RGB_W-1:0]   src,
  input  logic [csb_pkg::RGB_W-1:0]   dst,
  output logic [csb_pkg::RGB_W-1:0]   mix
);
  import csb_pkg::*;

  logic [ALPHA_W-1:0] a;
  logic [ALPHA_W-1:0] inv;
  logic [16:0]        acc [3];

  // saturate anything at or above full weight to a plain copy
  assign a   = alpha[ALPHA_W-1] ? ALPHA_FULL : alpha;
  assign inv = ALPHA_FULL - a;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = 17'(src[c*8 +: 8]) * 17'(a) + 17'(dst[c*8 +: 8]) * 17'(inv);
      mix[c*8 +: 8] = acc[c][15:8];
    end
  end

endmodule

/* sv/clipped_alpha_sprite_blit.sv */
// Sprite blitter: takes sprite pixels in raster order with the frame-buffer
// colour at each destination, and emits a write beat (address, blended
// colour) for each opaque pixel inside the clip window and the frame buffer.
// Transparent or clipped pixels produce no beat but still advance the
// column/row walk; last_pixel restarts it. One pixel is accepted every clock
// while in_stall is low; a pixel's beat passes through an input stage and an
// output register. in_stall rises only while both stages are full and the
// output is stalled. Registers must be written over the APB port only while
// no pixel is in flight; the block itself does not enforce this.
module clipped_alpha_sprite_blit #(
  parameter int DEST_WIDTH  = csb_pkg::DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT = csb_pkg::DEST_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csb_pkg::ADDR_W-1:0]   paddr,
  input  logic [csb_pkg::DATA_W-1:0]   pwdata,
  output logic [csb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [csb_pkg::RGB_W-1:0]    src_rgb,
  input  logic [csb_pkg::RGB_W-1:0]    dst_rgb,
  input  logic                         last_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [csb_pkg::DADDR_W-1:0]  dest_address,
  output logic [csb_pkg::RGB_W-1:0]    colour
);
  import csb_pkg::*;

  cfg_t             cfg;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             in_acc;
  logic             out_free;

  logic             s1_valid;
  logic [RGB_W-1:0] s1_src;
  logic [RGB_W-1:0] s1_dst;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;

  clip_res_t        clip;
  logic [RGB_W-1:0] mix;

  csb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;

  csb_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_acc),
    .last_pixel   (last_pixel),
    .sprite_width (cfg.sprite_width),
    .col          (col),
    .row          (row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc || (s1_valid && !out_free);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src <= src_rgb;
      s1_dst <= dst_rgb;
      s1_col <= col;
      s1_row <= row;
    end
  end

  csb_clip #(
    .DEST_WIDTH  (DEST_WIDTH),
    .DEST_HEIGHT (DEST_HEIGHT)
  ) u_clip (
    .cfg    (cfg),
    .col    (s1_col),
    .row    (s1_row),
    .opaque (|s1_src),
    .res    (clip)
  );

  csb_blend u_blend (
    .alpha (cfg.alpha),
    .src   (s1_src),
    .dst   (s1_dst),
    .mix   (mix)
  );

  // drop pixels that miss; the stage still drains as a bubble
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && clip.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && clip.hit) begin
      dest_address <= clip.addr;
      colour       <= mix;
    end
  end

endmodule

/* sv/csb_chk.sv */
module csb_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] dest_address,
  input logic [23:0] colour,
  input logic        pready
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_address) && $stable(colour))
    else $error("output beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output beat without a pixel two cycles earlier");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port not ready");

endmodule

bind clipped_alpha_sprite_blit csb_chk u_csb_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .dest_address (dest_address),
  .colour       (colour),
  .pready       (pready)
);
